### hdl/cplim_pkg.sv
// ----------------------------------------------------------------------------
// Chassis power current limiter package
// Shared constants, configuration record and pipeline side-band types.
// ----------------------------------------------------------------------------
package cplim_pkg;

  localparam int MOTOR_COUNT = 4;

  // Pipelined divider geometry: 17-bit numerator shifted up by 16, 18-bit
  // divisor, 24 quotient bits (one per stage).
  localparam int DIV_NUM_W  = 17;
  localparam int DIV_DEN_W  = 18;
  localparam int DIV_STEPS  = 24;
  localparam int DIV_HEAD_W = DIV_NUM_W - 8;

  localparam int TOTAL_W = 18;
  localparam int LIMIT_W = 17;
  localparam int PROD_W  = 16 + DIV_STEPS;

  localparam logic [11:0] LOW_BUFFER_FLOOR = 12'd160;
  localparam logic [11:0] FLOOR_ENERGY     = 12'd80;
  localparam logic [15:0] CAP_OFF_COMMAND  = 16'd12000;
  localparam logic [15:0] CAP_CMD_SCALE    = 16'd100;
  localparam logic [15:0] CAP_CMD_OFFSET   = 16'd1500;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 17'd131071;

  localparam int ADDR_W = 5;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_WARN_BUFFER   = 3'd0;
  localparam logic [2:0] REG_WARN_MARGIN   = 3'd1;
  localparam logic [2:0] REG_NO_REF_LIMIT  = 3'd2;
  localparam logic [2:0] REG_BUFFER_LIMIT  = 3'd3;
  localparam logic [2:0] REG_POWER_LIMIT   = 3'd4;
  localparam logic [2:0] REG_CAP_LOW       = 3'd5;

  typedef struct packed {
    logic [11:0] warning_buffer_energy;
    logic [11:0] warning_power_margin;
    logic [15:0] no_referee_current_limit;
    logic [15:0] buffer_current_limit;
    logic [15:0] power_current_limit;
    logic [15:0] cap_low_energy;
  } cfg_t;

  typedef struct packed {
    logic                         referee;
    logic                         buf_low;
    logic                         pwr_near;
    logic                         cap_en;
    logic [15:0]                  cap_cmd;
    logic [MOTOR_COUNT-1:0][15:0] cur;
    logic [TOTAL_W-1:0]           total;
  } side_t;

endpackage

### hdl/cplim_if.sv
// ----------------------------------------------------------------------------
// Chassis power current limiter channels
// Valid/ready interfaces for the input snapshot and the limited result.
// ----------------------------------------------------------------------------
interface cplim_in_if;
  logic        valid;
  logic        ready;
  logic        referee_present;
  logic [11:0] measured_power;
  logic [11:0] buffer_energy;
  logic [11:0] power_limit;
  logic [15:0] cap_energy;
  logic        cap_request;
  logic signed [15:0] current_in_0;
  logic signed [15:0] current_in_1;
  logic signed [15:0] current_in_2;
  logic signed [15:0] current_in_3;

  modport source (output valid, referee_present, measured_power, buffer_energy,
                  power_limit, cap_energy, cap_request, current_in_0,
                  current_in_1, current_in_2, current_in_3, input ready);
  modport sink (input valid, referee_present, measured_power, buffer_energy,
                power_limit, cap_energy, cap_request, current_in_0,
                current_in_1, current_in_2, current_in_3, output ready);
endinterface

interface cplim_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] current_out_0;
  logic signed [15:0] current_out_1;
  logic signed [15:0] current_out_2;
  logic signed [15:0] current_out_3;
  logic [16:0] total_limit;
  logic        cap_enabled;
  logic [15:0] cap_power_command;

  modport source (output valid, current_out_0, current_out_1, current_out_2,
                  current_out_3, total_limit, cap_enabled, cap_power_command,
                  input ready);
  modport sink (input valid, current_out_0, current_out_1, current_out_2,
                current_out_3, total_limit, cap_enabled, cap_power_command,
                output ready);
endinterface

### hdl/cplim_regs.sv
// ----------------------------------------------------------------------------
// Chassis power current limiter registers
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module cplim_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cplim_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output cplim_pkg::cfg_t           cfg
);
  import cplim_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warning_buffer_energy    <= 12'd800;
      cfg.warning_power_margin     <= 12'd320;
      cfg.no_referee_current_limit <= 16'd64000;
      cfg.buffer_current_limit     <= 16'd16000;
      cfg.power_current_limit      <= 16'd20000;
      cfg.cap_low_energy           <= 16'd700;
    end else if (wr) begin
      unique case (idx)
        REG_WARN_BUFFER:  cfg.warning_buffer_energy    <= pwdata[11:0];
        REG_WARN_MARGIN:  cfg.warning_power_margin     <= pwdata[11:0];
        REG_NO_REF_LIMIT: cfg.no_referee_current_limit <= pwdata[15:0];
        REG_BUFFER_LIMIT: cfg.buffer_current_limit     <= pwdata[15:0];
        REG_POWER_LIMIT:  cfg.power_current_limit      <= pwdata[15:0];
        REG_CAP_LOW:      cfg.cap_low_energy           <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WARN_BUFFER:  prdata = {20'd0, cfg.warning_buffer_energy};
      REG_WARN_MARGIN:  prdata = {20'd0, cfg.warning_power_margin};
      REG_NO_REF_LIMIT: prdata = {16'd0, cfg.no_referee_current_limit};
      REG_BUFFER_LIMIT: prdata = {16'd0, cfg.buffer_current_limit};
      REG_POWER_LIMIT:  prdata = {16'd0, cfg.power_current_limit};
      REG_CAP_LOW:      prdata = {16'd0, cfg.cap_low_energy};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

### hdl/cplim_div.sv
// ----------------------------------------------------------------------------
// Chassis power current limiter divider
// Pipelined restoring divider giving (num << 16) / den, one quotient bit per
// stage. The caller guarantees num < den << 8 so the upper bits are zero.
// ----------------------------------------------------------------------------
module cplim_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [cplim_pkg::DIV_NUM_W-1:0] num,
  input  logic [cplim_pkg::DIV_DEN_W-1:0] den,
  output logic [cplim_pkg::DIV_STEPS-1:0] quo
);
  import cplim_pkg::*;

  logic [DIV_DEN_W-1:0] rem_r  [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_r  [DIV_STEPS];
  logic [DIV_STEPS-1:0] bits_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r  [DIV_STEPS];

  logic [DIV_DEN_W-1:0] rem_next  [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_next  [DIV_STEPS];
  logic [DIV_STEPS-1:0] bits_next [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_next  [DIV_STEPS];

  always_comb begin
    logic [DIV_DEN_W-1:0] rem_src;
    logic [DIV_DEN_W-1:0] den_src;
    logic [DIV_STEPS-1:0] bits_src;
    logic [DIV_STEPS-1:0] quo_src;
    logic [DIV_DEN_W:0]   trial;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        rem_src  = DIV_DEN_W'(num[DIV_NUM_W-1:8]);
        den_src  = den;
        bits_src = {num[7:0], 16'd0};
        quo_src  = '0;
      end else begin
        rem_src  = rem_r[k-1];
        den_src  = den_r[k-1];
        bits_src = bits_r[k-1];
        quo_src  = quo_r[k-1];
      end
      trial = {rem_src, bits_src[DIV_STEPS-1]};
      if (trial >= {1'b0, den_src}) begin
        rem_next[k] = DIV_DEN_W'(trial - {1'b0, den_src});
        quo_next[k] = {quo_src[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_next[k] = trial[DIV_DEN_W-1:0];
        quo_next[k] = {quo_src[DIV_STEPS-2:0], 1'b0};
      end
      den_next[k]  = den_src;
      bits_next[k] = {bits_src[DIV_STEPS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k]  <= rem_next[k];
        den_r[k]  <= den_next[k];
        bits_r[k] <= bits_next[k];
        quo_r[k]  <= quo_next[k];
      end
    end
  end

  assign quo = quo_r[DIV_STEPS-1];

endmodule

### hdl/chassis_power_current_limiter_core.sv
// ----------------------------------------------------------------------------
// Chassis power current limiter core
// Derives a total current limit from referee power data, scales the motor
// setpoints to it and sets the supercap switch and power command.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  in_ch    | in        | valid/ready      | referee and cap data, 4 setpoints
//  out_ch   | out       | valid/ready      | 4 currents, limit, cap controls
//  apb      | in        | psel/penable     | six configuration registers
//
// One transaction is accepted per cycle while the pipeline is not held; the
// pipeline is two 24-stage pipelined dividers plus five arithmetic stages.
// Reset clears every valid bit and loads the register defaults.
// The whole pipeline holds while the output register is full and not taken,
// so in_ch.ready follows out_ch.ready.
module chassis_power_current_limiter_core (
  input  logic                          clk,
  input  logic                          rst,
  cplim_in_if.sink                      in_ch,
  cplim_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cplim_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import cplim_pkg::*;

  cfg_t cfg;
  logic adv;

  cplim_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  // Stage A: branch selection, divider operands, cap decision, current sum.
  logic                 va;
  side_t                sa;
  logic [DIV_NUM_W-1:0] num1;
  logic [DIV_DEN_W-1:0] den1;
  side_t                sa_next;
  logic [DIV_NUM_W-1:0] num1_next;
  logic [DIV_DEN_W-1:0] den1_next;

  always_comb begin
    logic [MOTOR_COUNT-1:0][15:0] cur;
    logic [TOTAL_W-1:0]           sum;
    logic signed [16:0]           v;
    logic [16:0]                  mag;
    logic [11:0]                  n;
    logic [11:0]                  d;
    logic                         cap;
    cur = {in_ch.current_in_3, in_ch.current_in_2, in_ch.current_in_1,
           in_ch.current_in_0};
    sum = '0;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      v   = 17'(signed'(cur[k]));
      mag = v[16] ? 17'(-v) : 17'(v);
      sum = sum + TOTAL_W'(mag);
    end
    sa_next.referee  = in_ch.referee_present;
    sa_next.buf_low  = in_ch.buffer_energy < cfg.warning_buffer_energy;
    sa_next.pwr_near = ({1'b0, in_ch.measured_power} +
                        {1'b0, cfg.warning_power_margin}) >
                       {1'b0, in_ch.power_limit};
    cap = in_ch.cap_request;
    if (in_ch.referee_present && in_ch.cap_energy < cfg.cap_low_energy) begin
      cap = 1'b0;
    end
    sa_next.cap_en = cap;
    if (in_ch.referee_present && cap) begin
      sa_next.cap_cmd = 16'({12'd0, in_ch.power_limit[11:4]} * CAP_CMD_SCALE
                            + CAP_CMD_OFFSET);
    end else begin
      sa_next.cap_cmd = CAP_OFF_COMMAND;
    end
    sa_next.cur   = cur;
    sa_next.total = sum;
    if (sa_next.buf_low) begin
      n = (in_ch.buffer_energy > LOW_BUFFER_FLOOR) ? in_ch.buffer_energy
                                                   : FLOOR_ENERGY;
      d = cfg.warning_buffer_energy;
    end else begin
      n = (in_ch.measured_power < in_ch.power_limit)
          ? 12'(in_ch.power_limit - in_ch.measured_power) : 12'd0;
      d = cfg.warning_power_margin;
    end
    // A zero divisor yields a zero fraction: zero is divided by one instead.
    num1_next = (d == 12'd0) ? '0 : DIV_NUM_W'(n);
    den1_next = (d == 12'd0) ? DIV_DEN_W'(1) : DIV_DEN_W'(d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa   <= sa_next;
      num1 <= num1_next;
      den1 <= den1_next;
    end
  end

  // First divider: buffer or power fraction.
  logic [DIV_STEPS-1:0] q1;
  logic                 v1  [DIV_STEPS];
  side_t                sb1 [DIV_STEPS];

  cplim_div u_div_frac (
    .clk, .en(adv), .num(num1), .den(den1), .quo(q1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) v1[k] <= 1'b0;
    end else if (adv) begin
      v1[0] <= va;
      for (int k = 1; k < DIV_STEPS; k++) v1[k] <= v1[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb1[0] <= sa;
      for (int k = 1; k < DIV_STEPS; k++) sb1[k] <= sb1[k-1];
    end
  end

  // Stage M1: allowance times fraction.
  logic              vm1;
  side_t             sm1;
  logic [PROD_W-1:0] prod1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
    end else if (adv) begin
      vm1 <= v1[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm1   <= sb1[DIV_STEPS-1];
      prod1 <= PROD_W'((sb1[DIV_STEPS-1].buf_low ? cfg.buffer_current_limit
                                                 : cfg.power_current_limit)
                       * q1);
    end
  end

  // Stage M2: total limit with saturation, decide whether to scale.
  logic               vm2;
  side_t              sm2;
  logic [LIMIT_W-1:0] lim;
  logic               scale;
  logic [LIMIT_W-1:0] lim_next;

  always_comb begin
    logic [DIV_STEPS:0] wide;
    if (!sm1.referee) begin
      wide = (DIV_STEPS+1)'(cfg.no_referee_current_limit);
    end else if (sm1.buf_low) begin
      wide = (DIV_STEPS+1)'(prod1[PROD_W-1:16]);
    end else if (sm1.pwr_near) begin
      wide = (DIV_STEPS+1)'(cfg.buffer_current_limit) +
             (DIV_STEPS+1)'(prod1[PROD_W-1:16]);
    end else begin
      wide = (DIV_STEPS+1)'(cfg.buffer_current_limit) +
             (DIV_STEPS+1)'(cfg.power_current_limit);
    end
    lim_next = (wide > (DIV_STEPS+1)'(LIMIT_MAX)) ? LIMIT_MAX
                                                  : wide[LIMIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm2 <= 1'b0;
    end else if (adv) begin
      vm2 <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm2   <= sm1;
      lim   <= lim_next;
      scale <= TOTAL_W'(lim_next) < sm1.total;
    end
  end

  // Second divider: current scale limit / total.
  logic [DIV_STEPS-1:0] q2;
  logic                 v2   [DIV_STEPS];
  side_t                sb2  [DIV_STEPS];
  logic [LIMIT_W-1:0]   lim2 [DIV_STEPS];
  logic                 scl2 [DIV_STEPS];

  cplim_div u_div_scale (
    .clk, .en(adv), .num(lim), .den(sm2.total), .quo(q2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) v2[k] <= 1'b0;
    end else if (adv) begin
      v2[0] <= vm2;
      for (int k = 1; k < DIV_STEPS; k++) v2[k] <= v2[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb2[0]  <= sm2;
      lim2[0] <= lim;
      scl2[0] <= scale;
      for (int k = 1; k < DIV_STEPS; k++) begin
        sb2[k]  <= sb2[k-1];
        lim2[k] <= lim2[k-1];
        scl2[k] <= scl2[k-1];
      end
    end
  end

  // Stage F: magnitude times fraction for each motor.
  logic                         vf;
  side_t                        sf;
  logic [LIMIT_W-1:0]           limf;
  logic                         sclf;
  logic [MOTOR_COUNT-1:0][31:0] pf;
  logic [MOTOR_COUNT-1:0][31:0] pf_next;

  always_comb begin
    logic signed [16:0] v;
    logic [16:0]        mag;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      v          = 17'(signed'(sb2[DIV_STEPS-1].cur[k]));
      mag        = v[16] ? 17'(-v) : 17'(v);
      pf_next[k] = 32'(mag * q2[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (adv) begin
      vf <= v2[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sf   <= sb2[DIV_STEPS-1];
      limf <= lim2[DIV_STEPS-1];
      sclf <= scl2[DIV_STEPS-1];
      pf   <= pf_next;
    end
  end

  // Stage G: sign restore and output register.
  logic                         vg;
  logic [MOTOR_COUNT-1:0][15:0] cur_g;
  logic [LIMIT_W-1:0]           lim_g;
  logic                         cap_g;
  logic [15:0]                  cmd_g;
  logic [MOTOR_COUNT-1:0][15:0] cur_g_next;

  always_comb begin
    logic [15:0] m;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      m = pf[k][31:16];
      if (!sclf) begin
        cur_g_next[k] = sf.cur[k];
      end else if (sf.cur[k][15]) begin
        cur_g_next[k] = 16'(-m);
      end else begin
        cur_g_next[k] = m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (adv) begin
      vg <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cur_g <= cur_g_next;
      lim_g <= limf;
      cap_g <= sf.cap_en;
      cmd_g <= sf.cap_cmd;
    end
  end

  assign adv         = !vg || out_ch.ready;
  assign in_ch.ready = adv;

  assign out_ch.valid             = vg;
  assign out_ch.current_out_0     = signed'(cur_g[0]);
  assign out_ch.current_out_1     = signed'(cur_g[1]);
  assign out_ch.current_out_2     = signed'(cur_g[2]);
  assign out_ch.current_out_3     = signed'(cur_g[3]);
  assign out_ch.total_limit       = lim_g;
  assign out_ch.cap_enabled       = cap_g;
  assign out_ch.cap_power_command = cmd_g;

endmodule

### dv/cplim_checker.sv
// ----------------------------------------------------------------------------
// Current limiter result checker
// Watches the snapshot and result channels and the register port, predicts
// each limited result from its own copy of the registers and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
module cplim_checker (
  input  logic        clk,
  input  logic        rst,
  cplim_in_if         in_ch,
  cplim_out_if        out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [cplim_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cplim_pkg::*;

  typedef struct packed {
    logic        referee;
    logic [11:0] power;
    logic [11:0] buffer;
    logic [11:0] plimit;
    logic [15:0] cap_energy;
    logic        cap_request;
    logic [3:0][15:0] cur;
  } snapshot_t;

  typedef struct packed {
    logic [3:0][15:0] cur;
    logic [16:0] total_limit;
    logic        cap_en;
    logic [15:0] cap_cmd;
  } limited_t;

  cfg_t      regs;
  limited_t  limited_q[$];

  function automatic logic [63:0] q16_ratio(input logic [63:0] num, input logic [63:0] den);
    if (den == 64'd0) return 64'd0;
    return (num << 16) / den;
  endfunction

  function automatic limited_t limit_currents(input snapshot_t s, input cfg_t c);
    limited_t    r;
    logic [63:0] lim;
    logic [63:0] frac;
    logic [63:0] sum;
    logic [63:0] mag;
    logic [63:0] m;
    longint      v;
    logic        cap_on;
    cap_on = s.cap_request;
    if (!s.referee) begin
      lim = c.no_referee_current_limit;
      r.cap_cmd = CAP_OFF_COMMAND;
    end else begin
      if (s.cap_energy < c.cap_low_energy) cap_on = 1'b0;
      r.cap_cmd = cap_on ? 16'((s.plimit >> 4) * 100 + 1500) : CAP_OFF_COMMAND;
      if (s.buffer < c.warning_buffer_energy) begin
        frac = q16_ratio((s.buffer > LOW_BUFFER_FLOOR) ? 64'(s.buffer) : 64'(FLOOR_ENERGY),
                         64'(c.warning_buffer_energy));
        lim = (64'(c.buffer_current_limit) * frac) >> 16;
      end else if (int'(s.power) > int'(s.plimit) - int'(c.warning_power_margin)) begin
        frac = (s.power < s.plimit) ?
               q16_ratio(64'(s.plimit - s.power), 64'(c.warning_power_margin)) : 64'd0;
        lim = 64'(c.buffer_current_limit) + ((64'(c.power_current_limit) * frac) >> 16);
      end else begin
        lim = 64'(c.buffer_current_limit) + 64'(c.power_current_limit);
      end
      if (lim > 64'(LIMIT_MAX)) lim = 64'(LIMIT_MAX);
    end
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      v = longint'($signed(s.cur[k]));
      sum += (v < 0) ? 64'(-v) : 64'(v);
    end
    frac = q16_ratio(lim, sum);
    for (int k = 0; k < 4; k++) begin
      v = longint'($signed(s.cur[k]));
      r.cur[k] = s.cur[k];
      if (sum > lim) begin
        mag = (v < 0) ? 64'(-v) : 64'(v);
        m = (mag * frac) >> 16;
        r.cur[k] = (v < 0) ? 16'(-longint'(m)) : 16'(m);
      end
    end
    r.total_limit = lim[16:0];
    r.cap_en = cap_on;
    return r;
  endfunction

  assign pending = limited_q.size();

  always @(posedge clk) begin
    snapshot_t s;
    limited_t  got;
    limited_t  want;
    if (rst) begin
      regs.warning_buffer_energy    <= 12'd800;
      regs.warning_power_margin     <= 12'd320;
      regs.no_referee_current_limit <= 16'd64000;
      regs.buffer_current_limit     <= 16'd16000;
      regs.power_current_limit      <= 16'd20000;
      regs.cap_low_energy           <= 16'd700;
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (3'(paddr >> 2))
          REG_WARN_BUFFER:  regs.warning_buffer_energy    <= pwdata[11:0];
          REG_WARN_MARGIN:  regs.warning_power_margin     <= pwdata[11:0];
          REG_NO_REF_LIMIT: regs.no_referee_current_limit <= pwdata[15:0];
          REG_BUFFER_LIMIT: regs.buffer_current_limit     <= pwdata[15:0];
          REG_POWER_LIMIT:  regs.power_current_limit      <= pwdata[15:0];
          REG_CAP_LOW:      regs.cap_low_energy           <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        s.referee     = in_ch.referee_present;
        s.power       = in_ch.measured_power;
        s.buffer      = in_ch.buffer_energy;
        s.plimit      = in_ch.power_limit;
        s.cap_energy  = in_ch.cap_energy;
        s.cap_request = in_ch.cap_request;
        s.cur         = {in_ch.current_in_3, in_ch.current_in_2,
                         in_ch.current_in_1, in_ch.current_in_0};
        limited_q.push_back(limit_currents(s, regs));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.cur = {out_ch.current_out_3, out_ch.current_out_2,
                   out_ch.current_out_1, out_ch.current_out_0};
        got.total_limit = out_ch.total_limit;
        got.cap_en      = out_ch.cap_enabled;
        got.cap_cmd     = out_ch.cap_power_command;
        if (limited_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result transaction at %0t", $realtime);
        end else begin
          want = limited_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch at %0t: cur %0d %0d %0d %0d lim %0d cap %0b cmd %0d, expected %0d %0d %0d %0d lim %0d cap %0b cmd %0d",
                       $realtime, $signed(got.cur[0]), $signed(got.cur[1]),
                       $signed(got.cur[2]), $signed(got.cur[3]), got.total_limit,
                       got.cap_en, got.cap_cmd, $signed(want.cur[0]),
                       $signed(want.cur[1]), $signed(want.cur[2]), $signed(want.cur[3]),
                       want.total_limit, want.cap_en, want.cap_cmd);
          end
        end
      end
    end
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// Current limiter testbench
// Drives power snapshots with random gaps and output stalls through several
// register settings, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cplim_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        quiet;
  logic        hold_long;
  int          fail_count;
  int          pending;
  int          sent;
  int          referee_sent;
  // Local copy of the settings, used only to aim stimulus at the thresholds.
  int          warn_buf;
  int          warn_margin;
  int          cap_low;

  cplim_in_if  in_ch ();
  cplim_out_if out_ch ();

  chassis_power_current_limiter_core u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cplim_checker u_chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .psel(psel),
    .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #50ms;
    $display("[chassis_power_current_limiter_core] ERROR");
    $finish;
  end

  // Result side: mostly ready, short and occasional long stalls, and one
  // long hold-off on request so that the pipeline fills and stalls its input.
  initial begin
    out_ch.ready <= 1'b0;
    hold_long <= 1'b0;
    forever begin
      int r;
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_ch.ready <= 1'b1;
        hold_long <= 1'b0;
      end else if (quiet || r < 70) begin
        out_ch.ready <= 1'b1;
      end else if (r < 96) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WARN_BUFFER: warn_buf    = val & 32'hFFF;
      REG_WARN_MARGIN: warn_margin = val & 32'hFFF;
      REG_CAP_LOW:     cap_low     = val & 32'hFFFF;
      default: ;
    endcase
  endtask

  // Called at a rising edge; returns at the edge after the gap that follows.
  task automatic send_snapshot(input logic referee, input int power, input int buffer,
                               input int plimit, input int cap_e, input logic cap_req,
                               input int c0, input int c1, input int c2, input int c3);
    int gap;
    int r;
    in_ch.valid           <= 1'b1;
    in_ch.referee_present <= referee;
    in_ch.measured_power  <= 12'(power);
    in_ch.buffer_energy   <= 12'(buffer);
    in_ch.power_limit     <= 12'(plimit);
    in_ch.cap_energy      <= 16'(cap_e);
    in_ch.cap_request     <= cap_req;
    in_ch.current_in_0    <= 16'(c0);
    in_ch.current_in_1    <= 16'(c1);
    in_ch.current_in_2    <= 16'(c2);
    in_ch.current_in_3    <= 16'(c3);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    if (referee) referee_sent++;
    r = $urandom_range(0, 99);
    gap = (quiet || r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(15, 50);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int rand_current();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (r < 4) return int'($urandom_range(0, 65535)) - 32768;
    if (r < 6) return 0;
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  task automatic send_random();
    int plimit;
    int power;
    int buffer;
    int cap_e;
    int r;
    plimit = $urandom_range(0, 4095);
    r = $urandom_range(0, 9);
    if (r < 5) power = plimit - warn_margin + int'($urandom_range(0, warn_margin + 200)) - 50;
    else power = $urandom_range(0, 4095);
    if (power < 0) power = 0;
    if (power > 4095) power = 4095;
    r = $urandom_range(0, 9);
    if (r < 3) buffer = $urandom_range(0, 240);
    else if (r < 6) buffer = warn_buf + int'($urandom_range(0, 20)) - 10;
    else buffer = $urandom_range(0, 4095);
    if (buffer < 0) buffer = 0;
    if (buffer > 4095) buffer = 4095;
    cap_e = ($urandom_range(0, 1) == 1) ? cap_low + int'($urandom_range(0, 4)) - 2
                                        : int'($urandom_range(0, 65535));
    if (cap_e < 0) cap_e = 0;
    if (cap_e > 65535) cap_e = 65535;
    send_snapshot($urandom_range(0, 7) != 0, power, buffer, plimit, cap_e,
                  $urandom_range(0, 1), rand_current(), rand_current(),
                  rand_current(), rand_current());
  endtask

  task automatic drain();
    wait (pending == 0);
    repeat (70) @(posedge clk);
  endtask

  task automatic set_all(input int wb, input int wm, input int nr, input int bl,
                         input int pl, input int cl);
    reg_write(REG_WARN_BUFFER, wb);
    reg_write(REG_WARN_MARGIN, wm);
    reg_write(REG_NO_REF_LIMIT, nr);
    reg_write(REG_BUFFER_LIMIT, bl);
    reg_write(REG_POWER_LIMIT, pl);
    reg_write(REG_CAP_LOW, cl);
  endtask

  initial begin
    rst <= 1'b1;
    quiet <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.referee_present <= 1'b0;
    in_ch.measured_power <= '0;
    in_ch.buffer_energy <= '0;
    in_ch.power_limit <= '0;
    in_ch.cap_energy <= '0;
    in_ch.cap_request <= 1'b0;
    in_ch.current_in_0 <= '0;
    in_ch.current_in_1 <= '0;
    in_ch.current_in_2 <= '0;
    in_ch.current_in_3 <= '0;
    sent = 0;
    referee_sent = 0;
    warn_buf = 800;
    warn_margin = 320;
    cap_low = 700;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners under the reset settings.
    send_snapshot(0, 4095, 0, 0, 0, 1, 16384, 16384, 16384, 16384);
    send_snapshot(0, 0, 4095, 4095, 65535, 0, -16384, -16384, -16384, -16384);
    send_snapshot(1, 100, 2000, 4095, 699, 1, 100, -100, 50, -50);
    send_snapshot(1, 100, 2000, 4095, 700, 1, 16384, -16384, 16384, -16384);
    send_snapshot(1, 100, 2000, 4095, 65535, 0, 1000, 2000, -3000, 4000);
    send_snapshot(1, 0, 0, 1000, 800, 1, 16384, 16384, 16384, 16384);
    send_snapshot(1, 0, 160, 1000, 800, 1, -32768, 0, 0, 0);
    send_snapshot(1, 0, 161, 1000, 800, 1, 32767, -32768, 32767, -32768);
    send_snapshot(1, 0, 799, 1000, 800, 1, 9000, -9000, 9000, -9000);
    send_snapshot(1, 0, 800, 1000, 800, 1, 16384, 16384, -16384, -16384);
    send_snapshot(1, 680, 800, 1000, 800, 1, 16384, 16384, 16384, 16384);
    send_snapshot(1, 681, 800, 1000, 800, 1, 16384, 16384, 16384, 16384);
    send_snapshot(1, 1000, 800, 1000, 800, 1, 16384, 16384, 16384, 16384);
    send_snapshot(1, 4095, 4095, 0, 800, 1, 16384, -16384, 1, -1);
    send_snapshot(1, 3000, 4095, 2000, 800, 1, 0, 0, 0, 0);
    send_snapshot(1, 100, 4095, 4095, 800, 1, -1, -1, -1, -1);
    send_snapshot(1, 4000, 4095, 4095, 800, 1, 32767, 32767, 32767, 32767);
    repeat (160) send_random();

    in_ch.valid <= 1'b0;
    drain();
    quiet <= 1'b1;
    set_all(1, 1, 0, 0, 0, 0);
    repeat (160) send_random();
    in_ch.valid <= 1'b0;

    drain();
    quiet <= 1'b0;
    set_all(4095, 4095, 65535, 65535, 65535, 65535);
    hold_long <= 1'b1;
    repeat (170) send_random();
    in_ch.valid <= 1'b0;

    // Zero threshold and margin: neither branch may divide.
    drain();
    set_all(0, 0, 12345, 30000, 40000, 0);
    repeat (160) send_random();
    in_ch.valid <= 1'b0;

    // A small threshold with large allowances drives the limit close to its 17-bit maximum.
    drain();
    set_all(10, 4095, 1, 65535, 65535, 1);
    repeat (160) send_random();
    in_ch.valid <= 1'b0;

    drain();
    set_all($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
    repeat (170) send_random();
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    $display("Run covered %0d snapshots (%0d with referee) over six register settings,",
             sent, referee_sent);
    $display("including zero and saturating limits, with random gaps and output stalls.");
    if (fail_count == 0) begin
      $display("[chassis_power_current_limiter_core] OK");
    end else begin
      $display("[chassis_power_current_limiter_core] ERROR");
    end
    $finish;
  end

endmodule

### chassis_power_current_limiter_core.f
hdl/cplim_pkg.sv
hdl/cplim_if.sv
hdl/cplim_regs.sv
hdl/cplim_div.sv
hdl/chassis_power_current_limiter_core.sv
dv/cplim_checker.sv
dv/tb.sv
